[src/tcp_pkg.sv]
// Shared types and constants of the terminal cursor positioner.
package tcp_pkg;

  // Largest pane dimension honoured; wider register values count as this.
  localparam int unsigned MaxDim = 1023;
  localparam logic [11:0] DimMax12 = 12'(MaxDim);

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_REGION_TOP    = 3'd2;
  localparam cfg_idx_t CFG_REGION_BOTTOM = 3'd3;
  localparam cfg_idx_t CFG_ORIGIN_ENABLE = 3'd4;

  // Position request modes
  localparam logic [1:0] POS_ABS    = 2'd0;
  localparam logic [1:0] POS_REL    = 2'd1;
  localparam logic [1:0] POS_ORIGIN = 2'd2;

  // Region rules
  localparam logic [1:0] RULE_IGNORE      = 2'd0;
  localparam logic [1:0] RULE_UNCROSS     = 2'd1;
  localparam logic [1:0] RULE_ORIGIN_LOCK = 2'd2;

  // Scroll request bits and scroll kinds
  localparam int SCROLL_FWD_BIT  = 0;
  localparam int SCROLL_BACK_BIT = 1;
  localparam logic [1:0] SCROLL_NONE   = 2'd0;
  localparam logic [1:0] SCROLL_SCREEN = 2'd1;
  localparam logic [1:0] SCROLL_REGION = 2'd2;

  typedef struct packed {
    logic [9:0]  screen_width;
    logic [9:0]  screen_height;
    logic [9:0]  region_top;
    logic [10:0] region_bottom;
    logic        origin_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         x_mode;
    logic signed [11:0] x_value;
    logic [1:0]         y_mode;
    logic signed [11:0] y_value;
    logic [1:0]         scroll_mode;
    logic [1:0]         region_rule;
    logic               allow_right_edge;
  } cmd_t;

  typedef struct packed {
    logic [9:0]         cursor_col;
    logic [9:0]         cursor_row;
    logic [1:0]         scroll_kind;
    logic signed [12:0] scroll_count;
    logic [9:0]         scroll_top;
    logic [9:0]         scroll_bottom;
  } res_t;

endpackage

[src/tcp_step.sv]
// Combinational cursor move: target, region bounds, scroll request and clamp.
module tcp_step (
  input  tcp_pkg::cfg_t  cfg_i,
  input  tcp_pkg::cmd_t  cmd_i,
  input  logic [9:0]     cur_col_i,
  input  logic [9:0]     cur_row_i,
  output tcp_pkg::res_t  res_o
);
  import tcp_pkg::*;

  always_comb begin
    logic [9:0]         w, h;
    logic               valid, origin, lock;
    logic signed [13:0] rt, rb, hs, ws, sr_top, sr_bot, cy, x, y, top, bottom, cnt, b;
    logic               do_scroll;

    w = ({2'b0, cfg_i.screen_width} > DimMax12) ? DimMax12[9:0] : cfg_i.screen_width;
    h = ({2'b0, cfg_i.screen_height} > DimMax12) ? DimMax12[9:0] : cfg_i.screen_height;
    rt = $signed({4'b0, cfg_i.region_top});
    rb = $signed({3'b0, cfg_i.region_bottom});
    hs = $signed({4'b0, h});
    ws = $signed({4'b0, w});
    cy = $signed({4'b0, cur_row_i});

    valid  = (rt < rb) && (rt < hs);
    origin = cfg_i.origin_enable && valid;
    sr_top = valid ? rt : 14'sd0;
    sr_bot = valid ? rb : hs;

    x = $signed({{2{cmd_i.x_value[11]}}, cmd_i.x_value});
    y = $signed({{2{cmd_i.y_value[11]}}, cmd_i.y_value});
    if (cmd_i.x_mode == POS_REL) x = x + $signed({4'b0, cur_col_i});
    if (cmd_i.y_mode == POS_REL) begin
      y = y + cy;
    end else if (cmd_i.y_mode == POS_ORIGIN && origin) begin
      y = y + rt;
    end

    // uncrossable: bounded when inside, or when the move would cross an edge
    lock = 1'b0;
    case (cmd_i.region_rule)
      RULE_UNCROSS: begin
        lock = (cy >= sr_top && y < sr_top) || (cy < sr_bot && y >= sr_bot) ||
               (cy < sr_bot && cy >= sr_top);
      end
      RULE_ORIGIN_LOCK: lock = origin;
      default:          lock = 1'b0;
    endcase
    top    = (lock && valid) ? sr_top : 14'sd0;
    bottom = (lock && valid) ? sr_bot : hs;

    do_scroll = 1'b0;
    cnt = 14'sd0;
    if (cmd_i.scroll_mode[SCROLL_BACK_BIT] && y < top) begin
      do_scroll = 1'b1;
      cnt = y - top;
    end else if (cmd_i.scroll_mode[SCROLL_FWD_BIT] && y >= bottom) begin
      do_scroll = 1'b1;
      cnt = y - bottom + 14'sd1;
    end

    b = (bottom > hs) ? hs : bottom;
    res_o.scroll_kind   = SCROLL_NONE;
    res_o.scroll_top    = '0;
    res_o.scroll_bottom = '0;
    if (do_scroll) begin
      if (top < b && !(top == 14'sd0 && b == hs)) begin
        res_o.scroll_kind   = SCROLL_REGION;
        res_o.scroll_top    = top[9:0];
        res_o.scroll_bottom = b[9:0];
      end else begin
        res_o.scroll_kind   = SCROLL_SCREEN;
        res_o.scroll_bottom = h;
      end
    end
    res_o.scroll_count = cnt[12:0];

    if (y >= bottom) y = bottom - 14'sd1;
    if (y < top) y = top;
    if (x >= ws) x = cmd_i.allow_right_edge ? ws : ws - 14'sd1;
    if (x < 14'sd0) x = 14'sd0;
    res_o.cursor_col = x[9:0];
    res_o.cursor_row = y[9:0];
  end

endmodule

[src/terminal_cursor_positioner_core.sv]
// Top level of the terminal cursor positioner: stream ports, registers, cursor state.
//
// One cursor command enters on the s_axis channel and yields exactly one result
// on the m_axis channel, in order. A command sits in an input register while the
// move, scroll request and clamp are worked out, and the result is written to an
// output register that drives m_axis_tvalid; the command passes from the input
// register to the output register as soon as the latter is free or being read.
// One command per cycle is sustained while the receiver keeps m_axis_tready high;
// the rate is set by the single compute stage, whose cursor update must land
// before the next command is evaluated.
// The output register parts the two sides: while a result waits for
// m_axis_tready, one more command is still taken into the input register; after
// that s_axis_tready drops until the receiver takes the waiting result.
// Configuration (pane size, scroll region, origin mode) is written via cfg_we_i /
// cfg_idx_i / cfg_wdata_i only while no command is in flight, a rule for the user
// that the block does not enforce. Reset clears the cursor to the top left, empties
// both registers and loads the default 80 by 24 pane, no scroll region, origin off.
module terminal_cursor_positioner_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  tcp_pkg::cfg_idx_t       cfg_idx_i,
  input  logic [10:0]             cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // x_value[11:0], y_value[23:12], scroll_mode[25:24], region_rule[27:26],
  // allow_right_edge[28], zero fill
  input  logic [31:0]             s_axis_tdata,
  // x_mode[1:0], y_mode[3:2]
  input  logic [3:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // cursor_col[9:0], cursor_row[19:10], scroll_count[32:20], scroll_top[42:33],
  // scroll_bottom[52:43], zero fill
  output logic [55:0]             m_axis_tdata,
  // scroll_kind[1:0]
  output logic [1:0]              m_axis_tuser
);
  import tcp_pkg::*;

  cfg_t       cfg_q;
  cmd_t       cmd_in, cmd_q;
  res_t       res_d, res_q;
  logic       in_vld_q, out_vld_q;
  logic [9:0] cur_col_q, cur_row_q;
  logic       advance, take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_in.x_mode           = s_axis_tuser[1:0];
    cmd_in.y_mode           = s_axis_tuser[3:2];
    cmd_in.x_value          = s_axis_tdata[11:0];
    cmd_in.y_value          = s_axis_tdata[23:12];
    cmd_in.scroll_mode      = s_axis_tdata[25:24];
    cmd_in.region_rule      = s_axis_tdata[27:26];
    cmd_in.allow_right_edge = s_axis_tdata[28];
  end

  tcp_step u_step (
    .cfg_i     (cfg_q),
    .cmd_i     (cmd_q),
    .cur_col_i (cur_col_q),
    .cur_row_i (cur_row_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 10'd80;
      cfg_q.screen_height <= 10'd24;
      cfg_q.region_top    <= '0;
      cfg_q.region_bottom <= '0;
      cfg_q.origin_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata_i[9:0];
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata_i[9:0];
        CFG_REGION_TOP:    cfg_q.region_top    <= cfg_wdata_i[9:0];
        CFG_REGION_BOTTOM: cfg_q.region_bottom <= cfg_wdata_i;
        CFG_ORIGIN_ENABLE: cfg_q.origin_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        cur_col_q <= res_d.cursor_col;
        cur_row_q <= res_d.cursor_row;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_in;
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.scroll_kind;
  assign m_axis_tdata  = {3'b0, res_q.scroll_bottom, res_q.scroll_top, res_q.scroll_count,
                          res_q.cursor_row, res_q.cursor_col};

`ifndef NO_ASSERTIONS
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready) else $error("input stalled with free output");

  a_no_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.scroll_kind == SCROLL_NONE) |->
      (res_q.scroll_count == '0 && res_q.scroll_top == '0 && res_q.scroll_bottom == '0))
    else $error("scroll fields set without a scroll");

  a_region_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.scroll_kind == SCROLL_REGION) |->
      (res_q.scroll_top < res_q.scroll_bottom)) else $error("empty scroll region");

  a_cursor_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (cur_col_q == res_q.cursor_col && cur_row_q == res_q.cursor_row))
    else $error("cursor state differs from issued result");
`endif

endmodule

[tb/terminal_cursor_positioner_core_test.sv]
// Self-checking testbench for the terminal cursor positioner core.
`timescale 1ns / 100ps

module terminal_cursor_positioner_core_test;
  import tcp_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 125;

  // Scroll requests, and the spare mode and rule codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_FWD   = 2'd1;
  localparam logic [1:0] REQ_BACK  = 2'd2;
  localparam logic [1:0] REQ_BOTH  = 2'd3;
  localparam logic [1:0] POS_SPARE  = 2'd3;
  localparam logic [1:0] RULE_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  cfg_idx_t    cfg_idx_i = '0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  terminal_cursor_positioner_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the pane registers and the cursor
  logic [9:0]  pane_w = 10'd80;
  logic [9:0]  pane_h = 10'd24;
  logic [9:0]  reg_top = '0;
  logic [10:0] reg_bot = '0;
  logic        org_en = 1'b0;
  logic [9:0]  cur_col_q = '0;
  logic [9:0]  cur_row_q = '0;

  res_t expected_moves[$];
  int   err_cnt = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_screen = 0;
  int   n_region = 0;
  int   n_panes = 1;
  int   cycle_cnt = 0;
  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  logic hold_req = 1'b0;
  logic hold_on = 1'b0;

  function automatic logic region_ok();
    return ({1'b0, reg_top} < reg_bot) && (reg_top < pane_h);
  endfunction

  // Cursor move, scroll request and clamp for one command; advances the cursor.
  function automatic res_t move_cursor(cmd_t c);
    int   w, h, rt, rb, cy, x, y, sr_top, sr_bot, top, bottom, cnt, b;
    logic valid, origin, lock, scrl;
    res_t r;
    w = int'(pane_w);
    h = int'(pane_h);
    rt = int'(reg_top);
    rb = int'(reg_bot);
    cy = int'(cur_row_q);
    valid = (rt < rb) && (rt < h);
    origin = org_en && valid;
    sr_top = valid ? rt : 0;
    sr_bot = valid ? rb : h;
    x = int'(c.x_value);
    y = int'(c.y_value);
    if (c.x_mode == POS_REL) x += int'(cur_col_q);
    if (c.y_mode == POS_REL) y += cy;
    else if (c.y_mode == POS_ORIGIN && origin) y += rt;

    top = 0;
    bottom = h;
    lock = 1'b0;
    if (c.region_rule == RULE_UNCROSS) begin
      lock = (cy >= sr_top && y < sr_top) || (cy < sr_bot && y >= sr_bot) ||
             (cy < sr_bot && cy >= sr_top);
    end else if (c.region_rule == RULE_ORIGIN_LOCK) begin
      lock = origin;
    end
    if (lock && valid) begin
      top = sr_top;
      bottom = sr_bot;
    end

    scrl = 1'b0;
    cnt = 0;
    if (c.scroll_mode[SCROLL_BACK_BIT] && y < top) begin
      scrl = 1'b1;
      cnt = y - top;
    end else if (c.scroll_mode[SCROLL_FWD_BIT] && y >= bottom) begin
      scrl = 1'b1;
      cnt = y - bottom + 1;
    end

    r = '0;
    if (scrl) begin
      b = (bottom > h) ? h : bottom;
      r.scroll_count = 13'(cnt);
      if (top < b && !(top == 0 && b == h)) begin
        r.scroll_kind = SCROLL_REGION;
        r.scroll_top = 10'(top);
        r.scroll_bottom = 10'(b);
      end else begin
        r.scroll_kind = SCROLL_SCREEN;
        r.scroll_bottom = 10'(h);
      end
    end

    if (y >= bottom) y = bottom - 1;
    if (y < top) y = top;
    if (x >= w) x = c.allow_right_edge ? w : w - 1;
    if (x < 0) x = 0;
    cur_col_q = 10'(x);
    cur_row_q = 10'(y);
    r.cursor_col = cur_col_q;
    r.cursor_row = cur_row_q;
    return r;
  endfunction

  function automatic cmd_t mk(logic [1:0] xm, int xv, logic [1:0] ym, int yv,
                              logic [1:0] sm, logic [1:0] rule, logic re);
    cmd_t c;
    c.x_mode = xm;
    c.x_value = 12'(xv);
    c.y_mode = ym;
    c.y_value = 12'(yv);
    c.scroll_mode = sm;
    c.region_rule = rule;
    c.allow_right_edge = re;
    return c;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int jitter(int bound);
    return bound + int'($urandom_range(0, 6)) - 3;
  endfunction

  // Random command, mostly aimed at the pane edges and region bounds.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   tgt;
    c.x_mode = 2'($urandom_range(0, 3));
    c.y_mode = 2'($urandom_range(0, 3));
    c.scroll_mode = 2'($urandom_range(0, 3));
    c.region_rule = 2'($urandom_range(0, 3));
    c.allow_right_edge = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: tgt = jitter(0);
      1, 2: tgt = jitter(int'(pane_w));
      default: tgt = $urandom_range(0, int'(pane_w));
    endcase
    if ($urandom_range(0, 5) == 0) c.x_value = 12'($urandom);
    else c.x_value = 12'((c.x_mode == POS_REL) ? tgt - int'(cur_col_q) : tgt);
    case ($urandom_range(0, 5))
      0: tgt = jitter(int'(reg_top));
      1: tgt = jitter(int'(reg_bot));
      2: tgt = jitter(int'(pane_h));
      3: tgt = jitter(0);
      4: tgt = jitter(int'(cur_row_q));
      default: tgt = $urandom_range(0, int'(pane_h));
    endcase
    if ($urandom_range(0, 5) == 0) begin
      c.y_value = 12'($urandom);
    end else if (c.y_mode == POS_REL) begin
      c.y_value = 12'(tgt - int'(cur_row_q));
    end else if (c.y_mode == POS_ORIGIN && org_en && region_ok()) begin
      c.y_value = 12'(tgt - int'(reg_top));
    end else begin
      c.y_value = 12'(tgt);
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic send_cmd(cmd_t c);
    int gap;
    gap = tx_idle ? idle_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {3'b000, c.allow_right_edge, c.region_rule, c.scroll_mode,
                    c.y_value, c.x_value};
    s_axis_tuser = {c.y_mode, c.x_mode};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_moves.push_back(move_cursor(c));
    n_sent++;
  endtask

  // Stop offering items and let every result come out.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_SCREEN_WIDTH:  pane_w = val[9:0];
      CFG_SCREEN_HEIGHT: pane_h = val[9:0];
      CFG_REGION_TOP:    reg_top = val[9:0];
      CFG_REGION_BOTTOM: reg_bot = val;
      CFG_ORIGIN_ENABLE: org_en = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_pane(int w, int h, int rt, int rb, logic org);
    settle();
    write_reg(CFG_SCREEN_WIDTH, 11'(w));
    write_reg(CFG_SCREEN_HEIGHT, 11'(h));
    write_reg(CFG_REGION_TOP, 11'(rt));
    write_reg(CFG_REGION_BOTTOM, 11'(rb));
    write_reg(CFG_ORIGIN_ENABLE, 11'(org));
    n_panes++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cursor_col    = m_axis_tdata[9:0];
      got.cursor_row    = m_axis_tdata[19:10];
      got.scroll_count  = m_axis_tdata[32:20];
      got.scroll_top    = m_axis_tdata[42:33];
      got.scroll_bottom = m_axis_tdata[52:43];
      got.scroll_kind   = m_axis_tuser;
      if (expected_moves.size() == 0) begin
        report_mismatch("result with none pending, col", int'(got.cursor_col), 0);
      end else begin
        want = expected_moves.pop_front();
        n_checked++;
        if (want.scroll_kind == SCROLL_SCREEN) n_screen++;
        if (want.scroll_kind == SCROLL_REGION) n_region++;
        if (got.cursor_col != want.cursor_col)
          report_mismatch("cursor_col", int'(got.cursor_col), int'(want.cursor_col));
        if (got.cursor_row != want.cursor_row)
          report_mismatch("cursor_row", int'(got.cursor_row), int'(want.cursor_row));
        if (got.scroll_kind != want.scroll_kind)
          report_mismatch("scroll_kind", int'(got.scroll_kind), int'(want.scroll_kind));
        if (got.scroll_count != want.scroll_count)
          report_mismatch("scroll_count", int'(got.scroll_count), int'(want.scroll_count));
        if (got.scroll_top != want.scroll_top)
          report_mismatch("scroll_top", int'(got.scroll_top), int'(want.scroll_top));
        if (got.scroll_bottom != want.scroll_bottom)
          report_mismatch("scroll_bottom", int'(got.scroll_bottom),
                          int'(want.scroll_bottom));
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off while hold_on is set
  initial begin
    int rest;
    rest = 0;
    forever begin
      @(negedge clk_i);
      if (hold_on || rest > 0) begin
        m_axis_tready = 1'b0;
        if (rest > 0) rest--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_idle) rest = idle_len();
      end
    end
  end

  // Hold-off, counted here in clock cycles
  initial begin
    int held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_on = 1'b1;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
        hold_on = 1'b0;
        while (hold_req) @(posedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset pane, both edges, both overflow directions, spare modes and spare rule
  task automatic test_directed_moves();
    send_cmd(mk(POS_ABS, 0, POS_ABS, 0, REQ_NONE, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_ABS, 2047, POS_ABS, 2047, REQ_BOTH, RULE_IGNORE, 1'b1));
    send_cmd(mk(POS_ABS, -2048, POS_ABS, -2048, REQ_BOTH, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_REL, 5, POS_REL, 7, REQ_NONE, RULE_UNCROSS, 1'b0));
    send_cmd(mk(POS_REL, -1, POS_REL, -1, REQ_NONE, RULE_ORIGIN_LOCK, 1'b0));
    send_cmd(mk(POS_SPARE, 79, POS_SPARE, 23, REQ_FWD, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_ABS, 80, POS_ABS, 10, REQ_NONE, RULE_SPARE, 1'b0));
    send_cmd(mk(POS_ABS, 80, POS_ABS, 10, REQ_NONE, RULE_IGNORE, 1'b1));
    send_cmd(mk(POS_REL, 0, POS_REL, 0, REQ_NONE, RULE_IGNORE, 1'b1));
    // forward-only ignores an upward overflow, backward-only a downward one
    send_cmd(mk(POS_ABS, 0, POS_ABS, -1, REQ_FWD, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 24, REQ_BACK, RULE_IGNORE, 1'b0));
  endtask

  task automatic test_region_cases();
    set_pane(80, 24, 4, 12, 1'b1);
    send_cmd(mk(POS_ABS, 0, POS_ORIGIN, 0, REQ_NONE, RULE_ORIGIN_LOCK, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ORIGIN, 20, REQ_BOTH, RULE_ORIGIN_LOCK, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_REL, -20, REQ_BOTH, RULE_UNCROSS, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 0, REQ_NONE, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 15, REQ_FWD, RULE_UNCROSS, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 23, REQ_BOTH, RULE_IGNORE, 1'b0));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 1, REQ_BOTH, RULE_UNCROSS, 1'b0));
    // region bottom past the pane height
    set_pane(1023, 1023, 0, 1024, 1'b1);
    send_cmd(mk(POS_ABS, 2047, POS_ABS, 2047, REQ_BOTH, RULE_ORIGIN_LOCK, 1'b1));
    send_cmd(mk(POS_ABS, 0, POS_ABS, 1022, REQ_FWD, RULE_ORIGIN_LOCK, 1'b0));
    set_pane(1, 1, 0, 1, 1'b1);
    send_cmd(mk(POS_REL, 1, POS_REL, 1, REQ_BOTH, RULE_IGNORE, 1'b1));
  endtask

  task automatic test_random_traffic();
    int wl[9] = '{80, 1, 1023, 40, 132, 1023, 10, 300, 0};
    int hl[9] = '{24, 1, 1023, 10, 50, 1023, 8, 200, 0};
    int tl[9] = '{2, 0, 0, 5, 60, 1000, 2, 30, 0};
    int bl[9] = '{20, 1, 1024, 3, 70, 1023, 6, 150, 0};
    logic ol[9] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    for (int p = 0; p < 9; p++) begin
      if (wl[p] == 0) begin
        set_pane($urandom_range(1, 1023), $urandom_range(1, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1024), 1'($urandom));
      end else begin
        set_pane(wl[p], hl[p], tl[p], bl[p], ol[p]);
      end
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      repeat (PhaseItems) send_cmd(random_cmd());
    end
  endtask

  // Receiver holds off while the sender keeps offering items back to back
  task automatic test_backpressure();
    set_pane(80, 24, 3, 18, 1'b1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (40) send_cmd(random_cmd());
    hold_req = 1'b0;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_moves();
    test_region_cases();
    test_random_traffic();
    test_backpressure();
    settle();
    $display("%0d cursor commands sent, %0d results checked over %0d pane settings",
             n_sent, n_checked, n_panes);
    $display("scrolls seen: %0d whole screen, %0d region only; %0d mismatches",
             n_screen, n_region, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
